// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define TDP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/tdp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test package
// Shared constants and the command and status types between controller and
// datapath.
// ----------------------------------------------------------------------------
package tdp_pkg;

  localparam int unsigned ValueWidth   = 16;
  localparam int unsigned FirstDivisor = 2;

  typedef struct packed {
    logic load;       // capture a new candidate, restart at the first divisor
    logic start_div;  // clear the remainder and reload the dividend shifter
    logic step;       // one restoring division step
    logic next_div;   // advance to the next divisor and its square
  } tdp_cmd_t;

  typedef struct packed {
    logic n_lt2;      // candidate is zero or one
    logic sq_gt_n;    // divisor squared exceeds the candidate
    logic rem_zero;   // remainder of the last division is zero
  } tdp_status_t;

endpackage

// ===== hw/rtl/tdp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test channels
// Valid/ready channels for candidate words and result words.
// ----------------------------------------------------------------------------
interface tdp_in_if #(
  parameter int unsigned VALUE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

interface tdp_out_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

// ===== hw/rtl/trial_division_prime_test_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test unit
// Reports whether an unsigned candidate word is prime by trial division.
// ----------------------------------------------------------------------------
// One candidate is tested at a time: the input takes a word only while the
// unit is idle, and the one-bit result goes into an output register, so a
// new candidate can be taken while the previous result still waits. Every
// divisor d = 2, 3, ... with d*d <= candidate is tried by a bit-serial
// restoring remainder unit at one bit per cycle; each divisor takes a bound
// check, VALUE_WIDTH division steps and a zero test, and a small factor
// ends the test early. Zero and one are reported as not prime.
module trial_division_prime_test_unit import tdp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdp_in_if.sink    in_i,
  tdp_out_if.source out_o
);

  tdp_cmd_t    cmd;
  tdp_status_t status;

  tdp_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .is_prime_o (out_o.is_prime),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  tdp_dp #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .candidate_i(in_i.candidate),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

// ===== hw/rtl/tdp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test datapath
// Holds the candidate, the running divisor and its square, and a bit-serial
// restoring remainder unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdp_dp import tdp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] candidate_i,
  input  tdp_cmd_t               cmd_i,
  output tdp_status_t            status_o
);

  // The divisor never passes floor(sqrt(n)) + 1, and its square stays
  // below 2^(VALUE_WIDTH+1).
  localparam int unsigned DW = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int unsigned SW = VALUE_WIDTH + 2;

  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [VALUE_WIDTH-1:0] sh_q, sh_d;
  logic [DW-1:0]          d_q, d_d;
  logic [SW-1:0]          sq_q, sq_d;
  logic [DW-1:0]          rem_q, rem_d;
  logic [DW:0]            trial;

  assign trial = {rem_q, sh_q[VALUE_WIDTH-1]};

  always_comb begin
    n_d   = n_q;
    sh_d  = sh_q;
    d_d   = d_q;
    sq_d  = sq_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      n_d   = candidate_i;
      d_d   = DW'(FirstDivisor);
      sq_d  = SW'(FirstDivisor * FirstDivisor);
      // The remainder left by the previous candidate may exceed the new divisor.
      rem_d = '0;
    end
    if (cmd_i.start_div) begin
      sh_d  = n_q;
      rem_d = '0;
    end
    if (cmd_i.step) begin
      sh_d = {sh_q[VALUE_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, d_q}) begin
        rem_d = DW'(trial - {1'b0, d_q});
      end else begin
        rem_d = trial[DW-1:0];
      end
    end
    if (cmd_i.next_div) begin
      // (d + 1)^2 = d^2 + 2d + 1
      sq_d = sq_q + SW'({d_q, 1'b0}) + SW'(1);
      d_d  = d_q + DW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q   <= DW'(FirstDivisor);
      sq_q  <= SW'(FirstDivisor * FirstDivisor);
      rem_q <= '0;
    end else begin
      d_q   <= d_d;
      sq_q  <= sq_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    sh_q <= sh_d;
  end

  assign status_o.n_lt2    = (n_q < VALUE_WIDTH'(FirstDivisor));
  assign status_o.sq_gt_n  = (sq_q > SW'(n_q));
  assign status_o.rem_zero = (rem_q == '0);

  `TDP_ASSERT(a_sq_tracks_div, sq_q == (SW'(d_q) * SW'(d_q)), "square out of step with divisor")
  `TDP_ASSERT(a_rem_below_div, rem_q < d_q, "partial remainder not below divisor")

endmodule

// ===== hw/rtl/tdp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test controller
// Sequences bound checks, division steps and divisor updates, and owns the
// output word register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdp_ctrl import tdp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_prime_o,
  output tdp_cmd_t    cmd_o,
  input  tdp_status_t status_i
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST,
    ST_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          verdict_q, verdict_d;
  logic          out_valid_q, out_valid_d;
  logic          is_prime_q, is_prime_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q;
    is_prime_d  = is_prime_q;
    cmd_o       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status_i.n_lt2) begin
          verdict_d = 1'b0;
          state_d   = ST_DONE;
        end else if (status_i.sq_gt_n) begin
          verdict_d = 1'b1;
          state_d   = ST_DONE;
        end else begin
          cmd_o.start_div = 1'b1;
          cnt_d           = '0;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (cnt_q == CW'(VALUE_WIDTH - 1)) begin
          state_d = ST_TEST;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_TEST: begin
        if (status_i.rem_zero) begin
          verdict_d = 1'b0;
          state_d   = ST_DONE;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_DONE: begin
        // The result word waits here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          is_prime_d  = verdict_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      verdict_q   <= 1'b0;
      out_valid_q <= 1'b0;
      is_prime_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      verdict_q   <= verdict_d;
      out_valid_q <= out_valid_d;
      is_prime_q  <= is_prime_d;
    end
  end

  `TDP_ASSERT(a_cnt_bound, (state_q != ST_DIV) || (cnt_q <= CW'(VALUE_WIDTH - 1)), "step counter past dividend width")
  `TDP_ASSERT(a_zero_rem_composite, (state_q == ST_TEST && status_i.rem_zero) |=> (state_q == ST_DONE && !verdict_q), "zero remainder not reported as composite")
  `TDP_ASSERT_NEVER(a_small_prime, state_q == ST_CHECK && status_i.n_lt2 && cmd_o.start_div, "division started for zero or one")

endmodule
